// ===== rtl/core/hfil_pkg.sv =====
// Shared types and codes for the hash first-index lookup engine.
package hfil_pkg;

    localparam int EPOCH_W = 8;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_LOOKUP = 2'd2
    } t_func;

    typedef struct packed {
        logic load;
        logic clear;
        logic sweep;
        logic advance;
        logic insert;
        logic emit_hit;
        logic emit_miss;
        logic emit_drop;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_valid;
        logic key_match;
        logic is_insert;
        logic table_full;
        logic probe_last;
        logic sweep_last;
        logic epoch_last;
    } t_dp_stat;

endpackage

// ===== rtl/core/hash_first_index_lookup.sv =====
// Top level of the hash first-index lookup engine for 64-bit integer keys.
//
// A command beat is taken when start is high and busy is low. i_func selects
// clear, insert or look up; i_key carries the key. Every clear, insert and
// look-up beat produces one result beat, shown for a single cycle with
// o_strobe high; the receiver cannot hold it off. Func code 3 is taken and
// ignored, with no result.
// An insert or look-up keeps busy high through S_SLOT_RD and S_SLOT_CHK, and
// through S_KEY_CHK too when its home slot is occupied; each further occupied
// slot on the probe chain repeats all three, set by the registered read of the
// slot table followed by the registered read of the key store.
// The result beat is shown in the cycle in which busy falls.
// Valid slots are marked by an epoch tag, so a clear moves the epoch on instead
// of writing the slots. Every 255th clear, and after reset, the whole slot table
// is swept, one slot per cycle, with busy high.
// Reset is synchronous and active low; the table starts empty.
module hash_first_index_lookup #(
    parameter int CAPACITY = 4096,
    parameter int SLOTS    = 8192
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_func,
    input  logic signed [63:0]              i_key,
    output logic                            o_strobe,
    output logic [$clog2(CAPACITY+1)-1:0]   o_position,
    output logic                            o_found,
    output logic                            o_status
);
    import hfil_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hfil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    hfil_dp #(
        .CAPACITY (CAPACITY),
        .SLOTS    (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_func     (i_func),
        .i_key      (i_key),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_strobe   (o_strobe),
        .o_position (o_position),
        .o_found    (o_found),
        .o_status   (o_status)
    );

endmodule

// ===== rtl/core/hfil_dp.sv =====
// Datapath of the lookup engine: key store, slot table, probe and result registers.
module hfil_dp #(
    parameter int CAPACITY = 4096,
    parameter int SLOTS    = 8192
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_func,
    input  logic signed [63:0]              i_key,
    input  hfil_pkg::t_dp_cmd               i_cmd,
    output hfil_pkg::t_dp_stat              o_stat,
    output logic                            o_strobe,
    output logic [$clog2(CAPACITY+1)-1:0]   o_position,
    output logic                            o_found,
    output logic                            o_status
);
    import hfil_pkg::*;

    localparam int CAW = $clog2(CAPACITY);
    localparam int LCW = $clog2(CAPACITY + 1);
    localparam int SAW = $clog2(SLOTS);
    localparam int SEW = EPOCH_W + CAW;

    logic [63:0]        key_mem [CAPACITY];
    logic [SEW-1:0]     slot_mem [SLOTS];

    logic [63:0]        r_key;
    logic               r_is_insert;
    logic [SAW-1:0]     r_slot;
    logic [SAW-1:0]     r_probe;
    logic [LCW-1:0]     r_loaded;
    logic [EPOCH_W-1:0] r_epoch;
    logic [SAW-1:0]     r_sweep;
    logic [SEW-1:0]     r_slot_rd;
    logic [63:0]        r_key_rd;
    logic               r_strobe;
    logic [LCW-1:0]     r_position;
    logic               r_found;
    logic               r_status;

    logic [SAW-1:0]     n_slot_next;
    logic [CAW-1:0]     slot_ref;
    logic [EPOCH_W-1:0] slot_epoch;

    function automatic logic [SAW-1:0] home_slot(input logic [63:0] key);
        logic [SAW-1:0] h;
        logic [SAW:0]   w;
        h = '0;
        for (int i = 0; i < 64; i++) begin
            h[i % SAW] = h[i % SAW] ^ key[i];
        end
        w = {1'b0, h};
        if (w >= (SAW+1)'(SLOTS)) begin
            w = w - (SAW+1)'(SLOTS);
        end
        return w[SAW-1:0];
    endfunction

    assign slot_ref    = r_slot_rd[CAW-1:0];
    assign slot_epoch  = r_slot_rd[SEW-1:CAW];
    assign n_slot_next = (r_slot == SAW'(SLOTS - 1)) ? '0 : r_slot + 1'b1;

    always_comb begin
        o_stat.slot_valid = (slot_epoch == r_epoch);
        o_stat.key_match  = (r_key_rd == r_key);
        o_stat.is_insert  = r_is_insert;
        o_stat.table_full = (r_loaded >= LCW'(CAPACITY));
        o_stat.probe_last = (r_probe == SAW'(SLOTS - 1));
        o_stat.sweep_last = (r_sweep == SAW'(SLOTS - 1));
        o_stat.epoch_last = &r_epoch;
    end

    always_ff @(posedge i_clk) begin
        r_slot_rd <= slot_mem[r_slot];
        r_key_rd  <= key_mem[slot_ref];
        if (i_cmd.sweep) begin
            slot_mem[r_sweep] <= '0;
        end else if (i_cmd.insert) begin
            slot_mem[r_slot] <= {r_epoch, r_loaded[CAW-1:0]};
        end
        if (i_cmd.insert) begin
            key_mem[r_loaded[CAW-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= i_key;
            r_is_insert <= (i_func == FUNC_INSERT);
            r_slot      <= home_slot(i_key);
            r_probe     <= '0;
        end else if (i_cmd.advance) begin
            r_slot  <= n_slot_next;
            r_probe <= r_probe + 1'b1;
        end
        if (i_cmd.clear) begin
            r_position <= '0;
            r_found    <= 1'b0;
            r_status   <= 1'b0;
        end else if (i_cmd.emit_hit) begin
            r_position <= LCW'(slot_ref);
            r_found    <= 1'b1;
            r_status   <= 1'b0;
        end else if (i_cmd.emit_miss || i_cmd.insert) begin
            r_position <= r_loaded;
            r_found    <= 1'b0;
            r_status   <= 1'b0;
        end else if (i_cmd.emit_drop) begin
            r_position <= r_loaded;
            r_found    <= 1'b0;
            r_status   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_epoch  <= EPOCH_W'(1);
            r_sweep  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.clear | i_cmd.emit_hit | i_cmd.emit_miss
                        | i_cmd.emit_drop | i_cmd.insert;
            if (i_cmd.clear) begin
                r_loaded <= '0;
                r_epoch  <= (&r_epoch) ? EPOCH_W'(1) : r_epoch + 1'b1;
            end else if (i_cmd.insert) begin
                r_loaded <= r_loaded + 1'b1;
            end
            if (i_cmd.sweep) begin
                r_sweep <= (r_sweep == SAW'(SLOTS - 1)) ? '0 : r_sweep + 1'b1;
            end
        end
    end

    assign o_strobe   = r_strobe;
    assign o_position = r_position;
    assign o_found    = r_found;
    assign o_status   = r_status;

endmodule

// ===== rtl/core/hfil_ctrl.sv =====
// Controller state machine that sequences clearing, probing and result beats.
module hfil_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_func,
    input  hfil_pkg::t_dp_stat  i_stat,
    output hfil_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import hfil_pkg::*;

    typedef enum logic [4:0] {
        S_SWEEP    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_SLOT_RD  = 5'b00100,
        S_SLOT_CHK = 5'b01000,
        S_KEY_CHK  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (t_func'(i_func))
                        FUNC_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            if (i_stat.epoch_last) begin
                                n_state = S_SWEEP;
                            end
                        end
                        FUNC_INSERT, FUNC_LOOKUP: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_SLOT_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SLOT_RD: begin
                n_state = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                if (i_stat.slot_valid) begin
                    n_state = S_KEY_CHK;
                end else begin
                    n_state = S_IDLE;
                    if (!i_stat.is_insert) begin
                        o_cmd.emit_miss = 1'b1;
                    end else if (i_stat.table_full) begin
                        o_cmd.emit_drop = 1'b1;
                    end else begin
                        o_cmd.insert = 1'b1;
                    end
                end
            end
            S_KEY_CHK: begin
                if (i_stat.key_match) begin
                    o_cmd.emit_hit = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_stat.probe_last) begin
                    n_state = S_IDLE;
                    if (i_stat.is_insert) begin
                        o_cmd.emit_drop = 1'b1;
                    end else begin
                        o_cmd.emit_miss = 1'b1;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_SLOT_RD;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== verif/tb_hash_first_index_lookup.sv =====
// Self-checking testbench for the hash first-index lookup engine, with a queue-fed driver.
`timescale 1ns / 100ps

module tb_hash_first_index_lookup;

    import hfil_pkg::*;

    localparam int          CAPACITY    = 4096;
    localparam int          SLOTS       = 8192;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          IDLE_PCT    = 21;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_WAIT  = 100;
    localparam logic [63:0] KEY_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key;
    } t_cmd_beat;

    typedef struct packed {
        logic [12:0] position;
        logic        found;
        logic        status;
    } t_lookup_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_func = FUNC_CLEAR;
    logic [63:0] i_key = '0;
    logic        busy;
    logic        o_strobe;
    logic [12:0] o_position;
    logic        o_found;
    logic        o_status;

    t_cmd_beat      cmd_queue[$];
    t_lookup_result expected_results[$];
    logic [63:0]    loaded_keys [0:CAPACITY-1];
    logic [12:0]    table_count = '0;
    logic           beat_taken = 1'b0;
    int             beats_sent = 0;
    int             errors = 0;
    int             cycles = 0;

    hash_first_index_lookup #(
        .CAPACITY (CAPACITY),
        .SLOTS    (SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_key      (i_key),
        .o_strobe   (o_strobe),
        .o_position (o_position),
        .o_found    (o_found),
        .o_status   (o_status)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int find_first(input logic [63:0] key);
        for (int i = 0; i < CAPACITY; i++) begin
            if (i >= table_count) return -1;
            if (loaded_keys[i] == key) return i;
        end
        return -1;
    endfunction

    task automatic predict_index(input logic [1:0] func, input logic [63:0] key);
        t_lookup_result res;
        int hit;
        res = '0;
        hit = find_first(key);
        case (func)
            FUNC_CLEAR: begin
                table_count = '0;
                expected_results.push_back(res);
            end
            FUNC_INSERT: begin
                if (hit >= 0) begin
                    res.position = hit[12:0];
                    res.found = 1'b1;
                end else if (table_count >= CAPACITY) begin
                    res.position = table_count;
                    res.status = 1'b1;
                end else begin
                    loaded_keys[table_count] = key;
                    res.position = table_count;
                    table_count = table_count + 13'd1;
                end
                expected_results.push_back(res);
            end
            FUNC_LOOKUP: begin
                if (hit >= 0) begin
                    res.position = hit[12:0];
                    res.found = 1'b1;
                end else begin
                    res.position = table_count;
                end
                expected_results.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_cmd(input logic [1:0] func, input logic [63:0] key);
        t_cmd_beat b;
        b.func = func;
        b.key = key;
        cmd_queue.push_back(b);
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(9))
            0: return '0;
            1: return KEY_ONES;
            2: return KEY_MIN;
            3: return KEY_MAX;
            4: return {32'h0, 32'($urandom)};
            5: return {32'($urandom), 32'h0};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        t_lookup_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, actual position %0d found %0b status %0b",
                             $time, o_position, o_found, o_status);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_position !== want.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, o_position);
                        errors++;
                    end
                    if (o_found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b", $time, want.found, o_found);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, o_status);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                predict_index(i_func, i_key);
                beat_taken <= 1'b1;
            end else begin
                beat_taken <= 1'b0;
            end
        end else begin
            beat_taken <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : driver
        t_cmd_beat b;
        logic calm;
        calm = (beats_sent >= 400) && (beats_sent < 700);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                b = cmd_queue.pop_front();
                start <= 1'b1;
                i_func <= b.func;
                i_key <= b.key;
                beats_sent <= beats_sent + 1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [63:0] epoch_pool [0:11];
        logic [63:0] recent_keys[$];
        logic [63:0] fill_keys[$];
        logic [63:0] k;
        int r;

        // Directed beats: extremes, every function, duplicates, absent keys and the unused code.
        push_cmd(FUNC_LOOKUP, '0);
        push_cmd(FUNC_INSERT, '0);
        push_cmd(FUNC_INSERT, KEY_ONES);
        push_cmd(FUNC_INSERT, KEY_MIN);
        push_cmd(FUNC_INSERT, KEY_MAX);
        push_cmd(FUNC_INSERT, 64'h0000_0001_0000_0000);
        push_cmd(FUNC_INSERT, 64'h0000_0000_0000_0001);
        push_cmd(FUNC_INSERT, KEY_ONES);
        push_cmd(FUNC_LOOKUP, KEY_MAX);
        push_cmd(FUNC_LOOKUP, 64'h0000_0000_0000_1234);
        push_cmd(FUNC_UNUSED, KEY_ONES);
        push_cmd(FUNC_UNUSED, 64'h5555_AAAA_5555_AAAA);
        push_cmd(FUNC_LOOKUP, KEY_ONES);
        push_cmd(FUNC_LOOKUP, 64'h0000_0001_0000_0001);
        push_cmd(FUNC_CLEAR, KEY_ONES);
        push_cmd(FUNC_LOOKUP, '0);
        push_cmd(FUNC_INSERT, KEY_MAX);
        push_cmd(FUNC_LOOKUP, KEY_ONES);
        push_cmd(FUNC_CLEAR, '0);
        push_cmd(FUNC_CLEAR, '0);
        push_cmd(FUNC_INSERT, '0);
        push_cmd(FUNC_INSERT, '0);
        push_cmd(FUNC_LOOKUP, KEY_MAX);

        // Many short tables from a small key set, so old slots meet new ones across clears.
        for (int i = 0; i < 12; i++) epoch_pool[i] = pick_key();
        for (int round = 0; round < 120; round++) begin
            push_cmd(FUNC_CLEAR, pick_key());
            push_cmd(FUNC_INSERT, epoch_pool[$urandom_range(11)]);
            if ($urandom_range(1) == 0) push_cmd(FUNC_INSERT, epoch_pool[$urandom_range(11)]);
            push_cmd(FUNC_LOOKUP, epoch_pool[$urandom_range(11)]);
        end

        for (int i = 0; i < 250; i++) begin
            if (recent_keys.size() > 0 && $urandom_range(1) == 0) begin
                k = recent_keys[$urandom_range(recent_keys.size() - 1)];
            end else begin
                k = pick_key();
                recent_keys.push_back(k);
                if (recent_keys.size() > 64) void'(recent_keys.pop_front());
            end
            r = $urandom_range(99);
            if (r < 8) push_cmd(FUNC_CLEAR, k);
            else if (r < 12) push_cmd(FUNC_UNUSED, k);
            else if (r < 55) push_cmd(FUNC_INSERT, k);
            else push_cmd(FUNC_LOOKUP, k);
        end

        // Build a larger table, with duplicates and look-ups mixed in.
        push_cmd(FUNC_CLEAR, '0);
        for (int i = 0; i < 340; i++) begin
            r = $urandom_range(9);
            if (r == 0 && fill_keys.size() > 0) begin
                push_cmd(FUNC_INSERT, fill_keys[$urandom_range(fill_keys.size() - 1)]);
            end else if (r == 1 && fill_keys.size() > 0) begin
                push_cmd(FUNC_LOOKUP, fill_keys[$urandom_range(fill_keys.size() - 1)]);
            end else begin
                k = {32'($urandom), 32'($urandom)};
                fill_keys.push_back(k);
                push_cmd(FUNC_INSERT, k);
            end
        end
        push_cmd(FUNC_INSERT, KEY_MIN);
        push_cmd(FUNC_INSERT, fill_keys[0]);
        push_cmd(FUNC_LOOKUP, pick_key());
        push_cmd(FUNC_LOOKUP, fill_keys[fill_keys.size() - 1]);
        push_cmd(FUNC_UNUSED, fill_keys[0]);
        push_cmd(FUNC_CLEAR, '0);
        push_cmd(FUNC_LOOKUP, fill_keys[0]);
        push_cmd(FUNC_INSERT, fill_keys[0]);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/hfil_pkg.sv
rtl/core/hfil_dp.sv
rtl/core/hfil_ctrl.sv
rtl/core/hash_first_index_lookup.sv
verif/tb_hash_first_index_lookup.sv
